// ===== rtl/csw_pkg.sv =====
package csw_pkg;

    localparam int CNT_W     = 16;
    localparam int TID_W     = 6;
    localparam int PICK_W    = 16;
    localparam int DIV_STEPS = PICK_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    localparam logic FUNC_WAIT   = 1'b0;
    localparam logic FUNC_SIGNAL = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV     = 6'b000010,
        ST_RD_SLOT = 6'b000100,
        ST_RD_LAST = 6'b001000,
        ST_WRITE   = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

endpackage

// ===== rtl/csw_in_if.sv =====
interface csw_in_if
    import csw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic              has_task;
    logic [TID_W-1:0]  task_id;
    logic [PICK_W-1:0] pick;

    modport source (output valid, func, has_task, task_id, pick, input ready);
    modport sink   (input valid, func, has_task, task_id, pick, output ready);
endinterface

// ===== rtl/csw_out_if.sv =====
interface csw_out_if
    import csw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    must_yield;
    logic                    blocked_valid;
    logic                    woken_valid;
    logic [TID_W-1:0]        woken_task;
    logic signed [CNT_W-1:0] count_after;
    logic                    overflow;

    modport source (output valid, must_yield, blocked_valid, woken_valid, woken_task,
                    count_after, overflow, input ready);
    modport sink   (input valid, must_yield, blocked_valid, woken_valid, woken_task,
                    count_after, overflow, output ready);
endinterface

// ===== rtl/counting_semaphore_waiter_table_top.sv =====
// Counting semaphore with a table of blocked task ids.
// Input channel in_ch carries one operation per beat: a wait (P) or a signal (V),
// the calling task and a random pick. Output channel out_ch returns exactly one
// result beat per operation, in order. cfg_we/cfg_data load the initial count;
// a write reloads the count and empties the waiter table.
// Steps: a wait, or a signal that wakes nobody, goes from ST_IDLE to ST_DONE, which
// moves the result into the output register; the next beat is taken back in ST_IDLE.
// A signal that wakes a waiter first reduces pick mod the waiter count in ST_DIV,
// two bits a cycle, then goes through ST_RD_SLOT, ST_RD_LAST and ST_WRITE (read the chosen
// slot, read the last entry, write the last entry into the slot).
// The table is a synchronous memory with registered read data; entries are
// only read below the waiter count, so it needs no clearing after reset.
// Reset sets the count to zero and the waiter count to zero.
// A finished result sits in the output register until taken; the block accepts
// the next beat meanwhile, and holds its following result until the register
// frees up.
module counting_semaphore_waiter_table_top
    import csw_pkg::*;
#(
    parameter int MAX_WAITERS = 32,
    parameter int MAX_TASKS   = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic signed [CNT_W-1:0] cfg_data,
    csw_in_if.sink                  in_ch,
    csw_out_if.source               out_ch
);

    localparam int AW = $clog2(MAX_WAITERS);
    localparam int CW = $clog2(MAX_WAITERS + 1);

    state_t                  state_reg, state_next;
    logic signed [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]           wcount_reg, wcount_next;
    logic [PICK_W-1:0]       pick_reg, pick_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic                    res_yield_reg, res_yield_next;
    logic                    res_blocked_reg, res_blocked_next;
    logic                    res_woken_reg, res_woken_next;
    logic [TID_W-1:0]        res_task_reg, res_task_next;
    logic                    res_ovf_reg, res_ovf_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_yield_reg, out_yield_next;
    logic                    out_blocked_reg, out_blocked_next;
    logic                    out_woken_reg, out_woken_next;
    logic [TID_W-1:0]        out_task_reg, out_task_next;
    logic signed [CNT_W-1:0] out_count_reg, out_count_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic [TID_W-1:0]        mem [MAX_WAITERS];
    logic [TID_W-1:0]        rd_data_reg;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [TID_W-1:0]        wr_data;
    logic [AW-1:0]           rd_addr;

    logic                    accept;
    logic                    out_free;
    logic signed [CNT_W-1:0] count_new;
    logic                    at_limit;
    logic                    id_ok;
    logic                    table_full;
    logic                    enqueue;
    logic [CW-1:0]           wlast;
    logic [CW-1:0]           rem_mid;

    function automatic logic [CW-1:0] rem_step(input logic [CW-1:0] r, input logic b,
                                               input logic [CW-1:0] d);
        logic [CW:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[CW-1:0];
    endfunction

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign wlast       = wcount_reg - CW'(1);
    assign table_full  = (wcount_reg >= CW'(MAX_WAITERS));
    assign id_ok       = (32'(in_ch.task_id) < 32'(MAX_TASKS));
    assign rem_mid     = rem_step(rem_reg, pick_reg[PICK_W-1], wcount_reg);

    always_comb
    begin
        if (in_ch.func == FUNC_WAIT)
        begin
            at_limit  = (count_reg == CNT_MIN);
            count_new = at_limit ? count_reg : count_reg - CNT_W'(1);
        end
        else
        begin
            at_limit  = (count_reg == CNT_MAX);
            count_new = at_limit ? count_reg : count_reg + CNT_W'(1);
        end
        enqueue = (in_ch.func == FUNC_WAIT) && count_new[CNT_W-1] && in_ch.has_task && id_ok;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        wcount_next      = wcount_reg;
        pick_next        = pick_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        res_yield_next   = res_yield_reg;
        res_blocked_next = res_blocked_reg;
        res_woken_next   = res_woken_reg;
        res_task_next    = res_task_reg;
        res_ovf_next     = res_ovf_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_yield_next   = out_yield_reg;
        out_blocked_next = out_blocked_reg;
        out_woken_next   = out_woken_reg;
        out_task_next    = out_task_reg;
        out_count_next   = out_count_reg;
        out_ovf_next     = out_ovf_reg;
        wr_en            = 1'b0;
        wr_addr          = wcount_reg[AW-1:0];
        wr_data          = in_ch.task_id;
        rd_addr          = rem_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next       = count_new;
                    res_yield_next   = (in_ch.func == FUNC_WAIT) && count_new[CNT_W-1];
                    res_blocked_next = enqueue && !table_full;
                    res_woken_next   = 1'b0;
                    res_task_next    = '0;
                    res_ovf_next     = at_limit || (enqueue && table_full);
                    pick_next        = in_ch.pick;
                    rem_next         = '0;
                    step_next        = '0;
                    state_next       = ST_DONE;
                    if (enqueue && !table_full)
                    begin
                        wr_en       = 1'b1;
                        wcount_next = wcount_reg + CW'(1);
                    end
                    if ((in_ch.func == FUNC_SIGNAL) && (count_new[CNT_W-1] || count_new == '0)
                        && (wcount_reg != '0))
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step(rem_mid, pick_reg[PICK_W-2], wcount_reg);
                pick_next = {pick_reg[PICK_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_RD_SLOT;
                end
            end
            ST_RD_SLOT:
            begin
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                rd_addr       = wlast[AW-1:0];
                res_task_next = rd_data_reg;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en          = 1'b1;
                wr_addr        = rem_reg[AW-1:0];
                wr_data        = rd_data_reg;
                wcount_next    = wlast;
                res_woken_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_yield_next   = res_yield_reg;
                    out_blocked_next = res_blocked_reg;
                    out_woken_next   = res_woken_reg;
                    out_task_next    = res_task_reg;
                    out_count_next   = count_reg;
                    out_ovf_next     = res_ovf_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            count_next  = cfg_data;
            wcount_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wcount_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wcount_reg    <= wcount_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg        <= pick_next;
        rem_reg         <= rem_next;
        res_yield_reg   <= res_yield_next;
        res_blocked_reg <= res_blocked_next;
        res_woken_reg   <= res_woken_next;
        res_task_reg    <= res_task_next;
        res_ovf_reg     <= res_ovf_next;
        out_yield_reg   <= out_yield_next;
        out_blocked_reg <= out_blocked_next;
        out_woken_reg   <= out_woken_next;
        out_task_reg    <= out_task_next;
        out_count_reg   <= out_count_next;
        out_ovf_reg     <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.must_yield    = out_yield_reg;
    assign out_ch.blocked_valid = out_blocked_reg;
    assign out_ch.woken_valid   = out_woken_reg;
    assign out_ch.woken_task    = out_task_reg;
    assign out_ch.count_after   = out_count_reg;
    assign out_ch.overflow      = out_ovf_reg;

    a_wcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wcount_reg <= CW'(MAX_WAITERS))
        else $error("waiter count above table depth");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (wcount_reg != '0))
        else $error("pick reduced by an empty waiter count");

    a_woken_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.woken_valid) |->
        (!out_ch.must_yield && !out_ch.blocked_valid
         && (out_ch.count_after[CNT_W-1] || out_ch.count_after == '0)))
        else $error("wake reported with a positive count or on a wait");

    a_blocked_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.blocked_valid) |-> out_ch.must_yield)
        else $error("enqueue reported without yield");

endmodule

// ===== tb/sv/counting_semaphore_waiter_table_top_tb.sv =====
module counting_semaphore_waiter_table_top_tb
    import csw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAITER_SLOTS   = 32;
    localparam int TASK_IDS       = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic              func;
        logic              has_task;
        logic [TID_W-1:0]  task_id;
        logic [PICK_W-1:0] pick;
    } sem_op_t;

    typedef struct {
        logic                    must_yield;
        logic                    blocked_valid;
        logic                    woken_valid;
        logic [TID_W-1:0]        woken_task;
        logic signed [CNT_W-1:0] count_after;
        logic                    overflow;
    } sem_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic signed [CNT_W-1:0] cfg_data;

    csw_in_if  in_ch ();
    csw_out_if out_ch ();

    counting_semaphore_waiter_table_top #(
        .MAX_WAITERS (WAITER_SLOTS),
        .MAX_TASKS   (TASK_IDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    logic signed [CNT_W-1:0] sem_level;
    int unsigned             waiter_total;
    logic [TID_W-1:0]        waiter_ids [WAITER_SLOTS];

    sem_result_t due_outcomes [$];
    sem_result_t head_outcome;

    int error_count;
    int ops_sent;
    int blocks_seen;
    int wakes_seen;
    int overflows_seen;
    int settings_tried;
    int hold_request;
    int burst_left;
    bit sender_bursty;
    int quiet_cycles;

    function automatic sem_result_t semaphore_step(sem_op_t op);
        sem_result_t r;
        int unsigned slot;
        r = '{default: '0};
        if (op.func == FUNC_WAIT)
        begin
            if (sem_level != CNT_MIN)
                sem_level = sem_level - 16'sd1;
            else
                r.overflow = 1'b1;
            if (sem_level < 0)
            begin
                r.must_yield = 1'b1;
                if (op.has_task && op.task_id < TASK_IDS)
                begin
                    if (waiter_total < WAITER_SLOTS)
                    begin
                        waiter_ids[waiter_total] = op.task_id;
                        waiter_total++;
                        r.blocked_valid = 1'b1;
                    end
                    else
                        r.overflow = 1'b1;
                end
            end
        end
        else
        begin
            if (sem_level != CNT_MAX)
                sem_level = sem_level + 16'sd1;
            else
                r.overflow = 1'b1;
            if (sem_level <= 0 && waiter_total > 0)
            begin
                slot = op.pick % waiter_total;
                r.woken_task = waiter_ids[slot];
                waiter_ids[slot] = waiter_ids[waiter_total-1];
                waiter_total--;
                r.woken_valid = 1'b1;
            end
        end
        r.count_after = sem_level;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic send_op(logic func, logic has_task, logic [TID_W-1:0] tid,
                           logic [PICK_W-1:0] pick);
        sem_op_t     op;
        sem_result_t r;
        int          gap;
        op = '{func: func, has_task: has_task, task_id: tid, pick: pick};
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.func     = op.func;
        in_ch.has_task = op.has_task;
        in_ch.task_id  = op.task_id;
        in_ch.pick     = op.pick;
        in_ch.valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = semaphore_step(op);
        due_outcomes.push_back(r);
        ops_sent++;
        blocks_seen    += r.blocked_valid;
        wakes_seen     += r.woken_valid;
        overflows_seen += r.overflow;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reload_semaphore(logic signed [CNT_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sem_level    = value;
        waiter_total = 0;
        settings_tried++;
    endtask

    task automatic test_reset_state();
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd0);
        send_op(FUNC_WAIT, 1'b1, 6'd12, 16'd0);
        send_op(FUNC_WAIT, 1'b1, 6'd0, 16'hFFFF);
        send_op(FUNC_WAIT, 1'b1, 6'd63, 16'd0);
        send_op(FUNC_WAIT, 1'b0, 6'd17, 16'd0);
        send_op(FUNC_SIGNAL, 1'b1, 6'd40, 16'hFFFF);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd0);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'h8001);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd3);
    endtask

    task automatic test_reload_clears_table();
        reload_semaphore(-16'sd2);
        send_op(FUNC_WAIT, 1'b1, 6'd9, 16'd0);
        send_op(FUNC_WAIT, 1'b1, 6'd42, 16'd0);
        reload_semaphore(-16'sd2);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd1);
    endtask

    task automatic test_count_ceiling();
        reload_semaphore(CNT_MAX);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd0);
        send_op(FUNC_WAIT, 1'b1, 6'd5, 16'd0);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd0);
        send_op(FUNC_SIGNAL, 1'b1, 6'd21, 16'd7);
    endtask

    task automatic test_count_floor();
        reload_semaphore(CNT_MIN);
        send_op(FUNC_WAIT, 1'b1, 6'd1, 16'd0);
        send_op(FUNC_WAIT, 1'b0, 6'd2, 16'd0);
        send_op(FUNC_WAIT, 1'b1, 6'd46, 16'd0);
        send_op(FUNC_SIGNAL, 1'b0, 6'd0, 16'd5);
    endtask

    task automatic test_table_full();
        int n;
        reload_semaphore(16'sd0);
        for (n = 0; n < WAITER_SLOTS + 3; n++)
            send_op(FUNC_WAIT, 1'b1, TID_W'($urandom_range(0, TASK_IDS-1)),
                    PICK_W'($urandom));
        for (n = 0; n < 6; n++)
            send_op(FUNC_SIGNAL, 1'b0, 6'd0, PICK_W'($urandom));
    endtask

    task automatic test_output_backpressure();
        int n;
        reload_semaphore(-16'sd1);
        sender_bursty = 1'b0;
        hold_request  = HOLD_CYCLES;
        for (n = 0; n < 30; n++)
            send_op(n % 3 == 2 ? FUNC_SIGNAL : FUNC_WAIT, 1'b1,
                    TID_W'($urandom_range(0, TASK_IDS-1)), PICK_W'($urandom));
        sender_bursty = 1'b1;
    endtask

    task automatic test_random_phases();
        int                      phase;
        int                      n;
        int                      wait_pct;
        logic signed [CNT_W-1:0] start_value;
        logic                    fn;
        logic [PICK_W-1:0]       pk;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: start_value = CNT_W'($urandom_range(0, 8) - 4);
                1: start_value = CNT_MAX;
                2: start_value = CNT_MIN;
                3: start_value = CNT_W'($urandom_range(0, 65535));
                4: start_value = -16'sd3;
                5: start_value = CNT_MAX - 16'sd1;
                6: start_value = CNT_MIN + 16'sd1;
                default: start_value = 16'sd0;
            endcase
            reload_semaphore(start_value);
            sender_bursty = (phase % 3) != 1;
            wait_pct = (phase == 4) ? 80 : $urandom_range(35, 65);
            for (n = 0; n < 100; n++)
            begin
                fn = ($urandom_range(0, 99) < wait_pct) ? FUNC_WAIT : FUNC_SIGNAL;
                case ($urandom_range(0, 7))
                    0, 1: pk = PICK_W'($urandom_range(0, 3));
                    2: pk = '1;
                    default: pk = PICK_W'($urandom_range(0, 65535));
                endcase
                send_op(fn, $urandom_range(0, 9) != 0,
                        TID_W'($urandom_range(0, TASK_IDS-1)), pk);
            end
        end
        sender_bursty = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int hold_left;
        int mode;
        int mode_left;
        int period;
        int tick;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        period    = 2;
        tick      = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                    period    = $urandom_range(2, 7);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = $urandom_range(0, 99) < 70;
                    2: out_ch.ready = (tick % period) != 0;
                    default: out_ch.ready = $urandom_range(0, 99) < 25;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_outcomes.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with nothing pending, expected none, actual count_after %0d",
                         $time, out_ch.count_after);
            end
            else
            begin
                head_outcome = due_outcomes.pop_front();
                check_field("must_yield", head_outcome.must_yield, out_ch.must_yield);
                check_field("blocked_valid", head_outcome.blocked_valid, out_ch.blocked_valid);
                check_field("woken_valid", head_outcome.woken_valid, out_ch.woken_valid);
                check_field("woken_task", head_outcome.woken_task, out_ch.woken_task);
                check_field("count_after", head_outcome.count_after, out_ch.count_after);
                check_field("overflow", head_outcome.overflow, out_ch.overflow);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no beat for %0d cycles, %0d results pending",
                 $time, WATCHDOG_LIMIT, due_outcomes.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_WAIT;
        in_ch.has_task = 1'b0;
        in_ch.task_id  = '0;
        in_ch.pick     = '0;
        error_count    = 0;
        ops_sent       = 0;
        blocks_seen    = 0;
        wakes_seen     = 0;
        overflows_seen = 0;
        settings_tried = 1;
        hold_request   = 0;
        burst_left     = 0;
        sender_bursty  = 1'b1;
        sem_level      = '0;
        waiter_total   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_reload_clears_table();
        test_count_ceiling();
        test_count_floor();
        test_table_full();
        test_output_backpressure();
        test_random_phases();

        drain_results();
        repeat (30) @(posedge clk);

        $display("Ran %0d semaphore operations over %0d initial counts, with bursty input",
                 ops_sent, settings_tried);
        $display("and stalled output: %0d tasks blocked, %0d woken, %0d overflow flags",
                 blocks_seen, wakes_seen, overflows_seen);
        if (error_count == 0 && due_outcomes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== counting_semaphore_waiter_table_top.f =====
rtl/csw_pkg.sv
rtl/csw_in_if.sv
rtl/csw_out_if.sv
rtl/counting_semaphore_waiter_table_top.sv
tb/sv/counting_semaphore_waiter_table_top_tb.sv
